@@ src/tsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared constants for the Taylor sine/cosine pipeline: internal fixed-point
// format, I/O widths and default series length.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // I/O format: signed Q3.28
  localparam int ANGLE_W   = 32;
  localparam int FRAC_BITS = 28;

  // Internal format: 64-bit two's complement, 44 fraction bits
  localparam int DATA_W   = 64;
  localparam int HALF_W   = DATA_W / 2;
  localparam int INT_FRAC = 44;
  localparam int SHIFT_W  = INT_FRAC - FRAC_BITS;

  // Bits of the full product that matter: everything up to the kept window
  localparam int PROD_W = DATA_W + INT_FRAC;

  localparam logic [DATA_W-1:0] ONE_Q     = DATA_W'(1) << INT_FRAC;
  localparam logic [DATA_W-1:0] PROD_RND  = DATA_W'(1) << (INT_FRAC - 1);
  localparam logic [DATA_W-1:0] FINAL_RND = DATA_W'(1) << (SHIFT_W - 1);

  // Series length
  localparam int TERMS_DEFAULT = 10;

  // Function select codes
  localparam logic FUNC_SIN = 1'b0;
  localparam logic FUNC_COS = 1'b1;

endpackage

@@ src/tsc_qmul.sv @@
// ----------------------------------------------------------------------------
// tsc_qmul
// Three-stage signed 64x64 fixed-point multiplier. Returns the product
// shifted right by INT_FRAC, rounded half up, low 64 bits kept. Carries a
// sideband word and a valid bit with matching latency.
// ----------------------------------------------------------------------------
module tsc_qmul #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [tsc_pkg::DATA_W-1:0]  a,
  input  logic [tsc_pkg::DATA_W-1:0]  b,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic [tsc_pkg::DATA_W-1:0]  prod,
  output logic [SIDE_W-1:0]           side_out
);
  import tsc_pkg::*;

  // Split operands: signed high half, unsigned low half, both 33 bits
  logic signed [HALF_W:0] a_hi, a_lo, b_hi, b_lo;
  logic signed [2*HALF_W+1:0] pp_hh, pp_hl, pp_lh, pp_ll;

  assign a_hi = {a[DATA_W-1], a[DATA_W-1:HALF_W]};
  assign a_lo = {1'b0, a[HALF_W-1:0]};
  assign b_hi = {b[DATA_W-1], b[DATA_W-1:HALF_W]};
  assign b_lo = {1'b0, b[HALF_W-1:0]};

  assign pp_hh = a_hi * b_hi;
  assign pp_hl = a_hi * b_lo;
  assign pp_lh = a_lo * b_hi;
  assign pp_ll = a_lo * b_lo;

  // Stage 1 registers: partial products
  logic [PROD_W-DATA_W-1:0]  s1_hh;
  logic [2*HALF_W+1:0]       s1_hl, s1_lh;
  logic [DATA_W-1:0]         s1_ll;
  logic [SIDE_W-1:0]         s1_side;
  logic                      s1_valid;

  // Stage 2 registers: cross terms merged, rounding added to low term
  logic [PROD_W-DATA_W-1:0]  s2_hh;
  logic [2*HALF_W+2:0]       s2_mid;
  logic [DATA_W:0]           s2_low;
  logic [SIDE_W-1:0]         s2_side;
  logic                      s2_valid;

  logic [PROD_W-1:0] sum;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // Stage 1: only the low bits of the high product reach the kept window
  always_ff @(posedge clk) begin
    if (en) begin
      s1_hh   <= pp_hh[PROD_W-DATA_W-1:0];
      s1_hl   <= pp_hl;
      s1_lh   <= pp_lh;
      s1_ll   <= pp_ll[DATA_W-1:0];
      s1_side <= side_in;
    end
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      s2_hh   <= s1_hh;
      s2_mid  <= {s1_hl[2*HALF_W+1], s1_hl} + {s1_lh[2*HALF_W+1], s1_lh};
      s2_low  <= {1'b0, s1_ll} + {1'b0, PROD_RND};
      s2_side <= s1_side;
    end
  end

  // Stage 3: final sum modulo 2^PROD_W, keep the window above INT_FRAC
  assign sum = {s2_hh, {DATA_W{1'b0}}}
             + {{(PROD_W-HALF_W-2*HALF_W-3){s2_mid[2*HALF_W+2]}}, s2_mid, {HALF_W{1'b0}}}
             + {{(PROD_W-DATA_W-1){1'b0}}, s2_low};

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= sum[PROD_W-1:INT_FRAC];
      side_out <= s2_side;
    end
  end

endmodule

@@ src/tsc_horner_step.sv @@
// ----------------------------------------------------------------------------
// tsc_horner_step
// One Horner step of the series: p_out = 1 - (y * p_in) * r(K), where r is
// the reciprocal of the neighboring factorial ratio for sine or cosine.
// Seven register stages: two multipliers and the subtract.
// ----------------------------------------------------------------------------
module tsc_horner_step #(
  parameter int K = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         func_in,
  input  logic [tsc_pkg::ANGLE_W-1:0]  angle_in,
  input  logic [tsc_pkg::DATA_W-1:0]   y_in,
  input  logic [tsc_pkg::DATA_W-1:0]   p_in,
  output logic                         out_valid,
  output logic                         func_out,
  output logic [tsc_pkg::ANGLE_W-1:0]  angle_out,
  output logic [tsc_pkg::DATA_W-1:0]   y_out,
  output logic [tsc_pkg::DATA_W-1:0]   p_out
);
  import tsc_pkg::*;

  localparam int SIDE_W = 1 + ANGLE_W + DATA_W;

  // Reciprocal constants, round half up of 2^INT_FRAC / d
  localparam logic [DATA_W-1:0] D_SIN     = DATA_W'((2 * K) * (2 * K + 1));
  localparam logic [DATA_W-1:0] D_COS     = DATA_W'((2 * K - 1) * (2 * K));
  localparam logic [DATA_W-1:0] RECIP_SIN = (ONE_Q + D_SIN / 2) / D_SIN;
  localparam logic [DATA_W-1:0] RECIP_COS = (ONE_Q + D_COS / 2) / D_COS;

  logic                 yp_valid, t_valid;
  logic [DATA_W-1:0]    yp, t;
  logic [SIDE_W-1:0]    yp_side, t_side;
  logic [DATA_W-1:0]    recip;

  // y * p
  tsc_qmul #(.SIDE_W(SIDE_W)) u_mul_yp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .a         (y_in),
    .b         (p_in),
    .side_in   ({func_in, angle_in, y_in}),
    .out_valid (yp_valid),
    .prod      (yp),
    .side_out  (yp_side)
  );

  // Constant follows the function select carried with the request
  assign recip = (yp_side[SIDE_W-1] == FUNC_COS) ? RECIP_COS : RECIP_SIN;

  // (y * p) * r
  tsc_qmul #(.SIDE_W(SIDE_W)) u_mul_r (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (yp_valid),
    .a         (yp),
    .b         (recip),
    .side_in   (yp_side),
    .out_valid (t_valid),
    .prod      (t),
    .side_out  (t_side)
  );

  // 1 - t, wraps modulo 2^64
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_out     <= ONE_Q - t;
      func_out  <= t_side[SIDE_W-1];
      angle_out <= t_side[SIDE_W-2:DATA_W];
      y_out     <= t_side[DATA_W-1:0];
    end
  end

endmodule

@@ src/taylor_sine_cosine.sv @@
// ----------------------------------------------------------------------------
// taylor_sine_cosine
// Fixed-point sine or cosine by a truncated Maclaurin series, evaluated as a
// fully pipelined Horner chain in x^2.
// ----------------------------------------------------------------------------
// One request per clock is accepted while the chain is not stalled, and one
// result per request comes out in order. The path from accept to the output
// runs through one input register, three for x*x, seven for each Horner step
// (two three-stage multipliers and a subtract), three for the final x*p, one
// for rounding and saturation and the output register. Every stage between
// the input and output registers holds one bank of 33x33 multipliers or one
// wide add. Backpressure stalls the whole chain; a skid register at the
// output keeps the input ready a registered signal, so a request is still
// taken while a result waits on the output. Angle and result are signed Q3.28;
// the result is clipped to the 32-bit range and flagged when clipped.
// ----------------------------------------------------------------------------
module taylor_sine_cosine #(
  parameter int TERMS = tsc_pkg::TERMS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // request side
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [tsc_pkg::ANGLE_W-1:0]  s_axis_tdata,   // [31:0] angle
  input  logic                         s_axis_tuser,   // [0] func
  // result side
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [tsc_pkg::ANGLE_W-1:0]  m_axis_tdata,   // [31:0] value
  output logic                         m_axis_tuser    // [0] saturated
);
  import tsc_pkg::*;

  localparam int STEPS = TERMS - 1;

  // Global advance: stall only when the skid register is occupied
  logic en;
  logic skid_valid;
  assign en            = ~skid_valid;
  assign s_axis_tready = en;

  // Input register
  logic               in_valid;
  logic               in_func;
  logic [ANGLE_W-1:0] in_angle;
  logic [DATA_W-1:0]  in_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_func  <= s_axis_tuser;
      in_angle <= s_axis_tdata;
    end
  end

  assign in_x = DATA_W'($signed(in_angle)) << SHIFT_W;

  // y = x * x
  logic                        y_valid;
  logic [DATA_W-1:0]           y;
  logic [ANGLE_W:0]            y_side;

  tsc_qmul #(.SIDE_W(ANGLE_W + 1)) u_mul_xx (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .a         (in_x),
    .b         (in_x),
    .side_in   ({in_func, in_angle}),
    .out_valid (y_valid),
    .prod      (y),
    .side_out  (y_side)
  );

  // Horner chain, highest term first
  logic               h_valid [STEPS+1];
  logic               h_func  [STEPS+1];
  logic [ANGLE_W-1:0] h_angle [STEPS+1];
  logic [DATA_W-1:0]  h_y     [STEPS+1];
  logic [DATA_W-1:0]  h_p     [STEPS+1];

  assign h_valid[0] = y_valid;
  assign h_func[0]  = y_side[ANGLE_W];
  assign h_angle[0] = y_side[ANGLE_W-1:0];
  assign h_y[0]     = y;
  assign h_p[0]     = ONE_Q;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    tsc_horner_step #(.K(STEPS - i)) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (h_valid[i]),
      .func_in   (h_func[i]),
      .angle_in  (h_angle[i]),
      .y_in      (h_y[i]),
      .p_in      (h_p[i]),
      .out_valid (h_valid[i+1]),
      .func_out  (h_func[i+1]),
      .angle_out (h_angle[i+1]),
      .y_out     (h_y[i+1]),
      .p_out     (h_p[i+1])
    );
  end

  // x * p for sine; cosine takes p as it stands
  logic               fx_valid;
  logic [DATA_W-1:0]  fx_x;
  logic [DATA_W-1:0]  xp;
  logic [DATA_W:0]    xp_side;

  assign fx_x = DATA_W'($signed(h_angle[STEPS])) << SHIFT_W;

  tsc_qmul #(.SIDE_W(DATA_W + 1)) u_mul_xp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (h_valid[STEPS]),
    .a         (fx_x),
    .b         (h_p[STEPS]),
    .side_in   ({h_func[STEPS], h_p[STEPS]}),
    .out_valid (fx_valid),
    .prod      (xp),
    .side_out  (xp_side)
  );

  // Round to the output format and saturate
  logic [DATA_W-1:0]  v_sel, v_rnd, v_shr;
  logic               pos_ovf, neg_ovf;
  logic               rs_valid;
  logic [ANGLE_W-1:0] rs_value;
  logic               rs_sat;

  assign v_sel   = (xp_side[DATA_W] == FUNC_COS) ? xp_side[DATA_W-1:0] : xp;
  assign v_rnd   = v_sel + FINAL_RND;
  assign v_shr   = DATA_W'($signed(v_rnd) >>> SHIFT_W);
  assign pos_ovf = ~v_shr[DATA_W-1] & (|v_shr[DATA_W-2:ANGLE_W-1]);
  assign neg_ovf =  v_shr[DATA_W-1] & ~(&v_shr[DATA_W-2:ANGLE_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rs_valid <= 1'b0;
    end else if (en) begin
      rs_valid <= fx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pos_ovf) begin
        rs_value <= {1'b0, {(ANGLE_W-1){1'b1}}};
      end else if (neg_ovf) begin
        rs_value <= {1'b1, {(ANGLE_W-1){1'b0}}};
      end else begin
        rs_value <= v_shr[ANGLE_W-1:0];
      end
      rs_sat <= pos_ovf | neg_ovf;
    end
  end

  // Output register with skid buffer
  logic               push;
  logic [ANGLE_W-1:0] skid_value;
  logic               skid_sat;

  assign push = rs_valid & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (m_axis_tready || !m_axis_tvalid) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !m_axis_tvalid) begin
      if (skid_valid) begin
        m_axis_tdata <= skid_value;
        m_axis_tuser <= skid_sat;
      end else begin
        m_axis_tdata <= rs_value;
        m_axis_tuser <= rs_sat;
      end
    end else if (push) begin
      skid_value <= rs_value;
      skid_sat   <= rs_sat;
    end
  end

endmodule
